// File: design/cphe_pkg.sv
// Shared types, constants and text tables for the code point HTML escaper.
`timescale 1ns / 1ps
package cphe_pkg;

    localparam int CP_W       = 21;            // code point width
    localparam int DIGITS     = 7;             // decimal digits of a 21-bit value
    localparam int BCD_W      = 4 * DIGITS;
    localparam int BCD_STAGES = 3;
    localparam int DD_STEPS   = CP_W / BCD_STAGES;   // shift steps per stage
    localparam int MAX_BYTES  = 10;
    localparam int LEN_W      = $clog2(MAX_BYTES + 1);
    localparam int IDX_W      = $clog2(MAX_BYTES);

    // character classes
    localparam logic [2:0] CLS_PASS = 3'd0;
    localparam logic [2:0] CLS_APOS = 3'd1;
    localparam logic [2:0] CLS_QUOT = 3'd2;
    localparam logic [2:0] CLS_LT   = 3'd3;
    localparam logic [2:0] CLS_GT   = 3'd4;
    localparam logic [2:0] CLS_AMP  = 3'd5;
    localparam logic [2:0] CLS_BR   = 3'd6;
    localparam logic [2:0] CLS_DEC  = 3'd7;

    // ASCII
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    typedef logic [MAX_BYTES-1:0][7:0] t_bytes;

    typedef struct packed {
        t_bytes            bytes;
        logic [LEN_W-1:0]  len;
    } t_text;

    // item as it moves through the conversion stages
    typedef struct packed {
        logic [2:0]       cls;
        logic [7:0]       ch;
        logic [CP_W-1:0]  bin;
        logic [BCD_W-1:0] bcd;
        logic             eot;
    } t_work;

    // one result byte
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_item;
        logic       end_of_string;
    } t_res;

    // fixed entity text for the named classes
    function automatic t_text ent_text(input logic [2:0] cls);
        t_text t;
        t.bytes = '0;
        t.len   = '0;
        unique case (cls)
            CLS_APOS: begin
                t.bytes[0] = CH_AMP; t.bytes[1] = CH_A; t.bytes[2] = CH_P;
                t.bytes[3] = CH_O;   t.bytes[4] = CH_S; t.bytes[5] = CH_SEMI;
                t.len = LEN_W'(6);
            end
            CLS_QUOT: begin
                t.bytes[0] = CH_AMP; t.bytes[1] = CH_Q; t.bytes[2] = CH_U;
                t.bytes[3] = CH_O;   t.bytes[4] = CH_T; t.bytes[5] = CH_SEMI;
                t.len = LEN_W'(6);
            end
            CLS_LT: begin
                t.bytes[0] = CH_AMP; t.bytes[1] = CH_L; t.bytes[2] = CH_T;
                t.bytes[3] = CH_SEMI;
                t.len = LEN_W'(4);
            end
            CLS_GT: begin
                t.bytes[0] = CH_AMP; t.bytes[1] = CH_G; t.bytes[2] = CH_T;
                t.bytes[3] = CH_SEMI;
                t.len = LEN_W'(4);
            end
            CLS_AMP: begin
                t.bytes[0] = CH_AMP; t.bytes[1] = CH_A; t.bytes[2] = CH_M;
                t.bytes[3] = CH_P;   t.bytes[4] = CH_SEMI;
                t.len = LEN_W'(5);
            end
            CLS_BR: begin
                t.bytes[0] = CH_LT;    t.bytes[1] = CH_B;  t.bytes[2] = CH_R;
                t.bytes[3] = CH_SLASH; t.bytes[4] = CH_GT;
                t.len = LEN_W'(5);
            end
            default: begin
                t.bytes = '0;
                t.len   = '0;
            end
        endcase
        return t;
    endfunction

endpackage

// File: design/cphe_if.sv
// Valid/ready channel interfaces for code points in and escaped bytes out.
`timescale 1ns / 1ps
interface cphe_in_if;
    logic                       valid;
    logic                       ready;
    logic [cphe_pkg::CP_W-1:0]  code_point;
    logic                       end_of_text;

    modport source (output valid, code_point, end_of_text, input ready);
    modport sink   (input valid, code_point, end_of_text, output ready);
endinterface

interface cphe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_item;
    logic       end_of_string;

    modport source (output valid, out_byte, last_of_item, end_of_string, input ready);
    modport sink   (input valid, out_byte, last_of_item, end_of_string, output ready);
endinterface

// File: design/cphe_bcd_stage.sv
// One pipeline stage of the binary to BCD conversion (shift and add-3).
`timescale 1ns / 1ps
module cphe_bcd_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  cphe_pkg::t_work i_work,
    output logic            o_valid,
    input  logic            i_ready,
    output cphe_pkg::t_work o_work
);
    import cphe_pkg::*;

    logic  r_valid;
    t_work r_work;
    t_work n_work;

    always_comb begin
        n_work = i_work;
        for (int s = 0; s < DD_STEPS; s++) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (n_work.bcd[4*d +: 4] >= 4'd5) begin
                    n_work.bcd[4*d +: 4] = n_work.bcd[4*d +: 4] + 4'd3;
                end
            end
            n_work.bcd = {n_work.bcd[BCD_W-2:0], n_work.bin[CP_W-1]};
            n_work.bin = {n_work.bin[CP_W-2:0], 1'b0};
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

// File: design/cphe_emit.sv
// Output stage: builds the escaped text of one item and sends it a byte per transfer.
`timescale 1ns / 1ps
module cphe_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  cphe_pkg::t_work i_work,
    output logic            o_valid,
    input  logic            i_ready,
    output cphe_pkg::t_res  o_res
);
    import cphe_pkg::*;

    logic                     r_valid;
    t_bytes                   r_bytes;
    logic [LEN_W-1:0]         r_len;
    logic [IDX_W-1:0]         r_idx;
    logic                     r_eot;

    t_bytes                   n_bytes;
    logic [LEN_W-1:0]         n_len;
    logic [DIGITS-1:0][3:0]   dig;
    logic [2:0]               ndig;
    logic [2:0]               pos;
    logic [2:0]               sel;
    t_text                    ent;
    logic                     is_last;
    logic                     done;

    assign dig = i_work.bcd;
    assign ent = ent_text(i_work.cls);

    // format the item
    always_comb begin
        ndig = 3'd1;
        for (int d = 1; d < DIGITS; d++) begin
            if (dig[d] != 4'd0) begin
                ndig = 3'(d + 1);
            end
        end
        n_bytes = '0;
        n_len   = '0;
        pos     = '0;
        sel     = '0;
        case (i_work.cls)
            CLS_PASS: begin
                n_bytes[0] = i_work.ch;
                n_len      = LEN_W'(1);
            end
            CLS_DEC: begin
                n_bytes[0] = CH_AMP;
                n_bytes[1] = CH_HASH;
                for (int k = 2; k < MAX_BYTES; k++) begin
                    pos = 3'(k - 2);
                    sel = ndig - 3'd1 - pos;
                    if (pos < ndig) begin
                        n_bytes[k] = CH_ZERO | {4'd0, dig[sel]};
                    end else if (pos == ndig) begin
                        n_bytes[k] = CH_SEMI;
                    end
                end
                n_len = LEN_W'(ndig) + LEN_W'(3);
            end
            default: begin
                n_bytes = ent.bytes;
                n_len   = ent.len;
            end
        endcase
    end

    assign is_last = (LEN_W'(r_idx) == (r_len - LEN_W'(1)));
    assign done    = r_valid && i_ready && is_last;
    assign o_ready = !r_valid || done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (o_ready) begin
            r_valid <= i_valid;
            r_idx   <= '0;
        end else if (r_valid && i_ready) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_bytes <= n_bytes;
            r_len   <= n_len;
            r_eot   <= i_work.eot;
        end
    end

    assign o_valid             = r_valid;
    assign o_res.out_byte      = r_bytes[r_idx];
    assign o_res.last_of_item  = is_last;
    assign o_res.end_of_string = is_last && r_eot;

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (LEN_W'(r_idx) < r_len))
        else $error("byte index past item length");
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_len != '0 && r_len <= LEN_W'(MAX_BYTES)))
        else $error("item length out of range");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_idx)))
        else $error("held item moved during stall");
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && !i_valid) |=> !r_valid)
        else $error("finished item not released");
`endif

endmodule

// File: design/code_point_html_escape_unit.sv
// Top level of the code point HTML escaper.
`timescale 1ns / 1ps
// Usage:
//   i_item carries one code point (21 bits) and an end_of_text flag per transfer.
//   o_result carries one escaped ASCII byte per transfer, with last_of_item on
//   the final byte of each code point and end_of_string on the final byte of
//   a code point that came with end_of_text set.
//   i_cfg_wr_en / i_cfg_wr_data write newline_as_break; write it only while
//   the block is empty.
// Path: each item passes three BCD stages (the first also classifying)
//   and then the output buffer, from which its bytes are offered.
// Throughput: one code point per cycle while each expands to a single byte and
//   o_result.ready is high. An item of N bytes (N = 1..10) holds the output
//   buffer until its last byte transfers; the byte-wide output sets the rate.
// Reset (synchronous, active low) empties every stage and clears the break
//   mode to 0.
// Stall: when o_result.ready is low the output byte holds and the pipeline
//   fills behind it; i_item.ready drops once all stages are occupied. Nothing
//   is lost or repeated.
module code_point_html_escape_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_wr_en,
    input  logic i_cfg_wr_data,
    cphe_in_if.sink    i_item,
    cphe_out_if.source o_result
);
    import cphe_pkg::*;

    logic   r_nl_break;

    // stage chain: index 0 is the entry, BCD_STAGES is the emit input
    logic   st_valid [BCD_STAGES+1];
    logic   st_ready [BCD_STAGES+1];
    t_work  st_work  [BCD_STAGES+1];

    logic [2:0] entry_cls;
    logic       cp_high;
    logic [6:0] cp_low;
    t_res       res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nl_break <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_nl_break <= i_cfg_wr_data;
        end
    end

    // classify the code point on entry
    assign cp_high = |i_item.code_point[CP_W-1:7];
    assign cp_low  = i_item.code_point[6:0];

    always_comb begin
        entry_cls = CLS_DEC;
        if (!cp_high) begin
            unique case ({1'b0, cp_low})
                CH_APOS: entry_cls = CLS_APOS;
                CH_QUOT: entry_cls = CLS_QUOT;
                CH_LT:   entry_cls = CLS_LT;
                CH_GT:   entry_cls = CLS_GT;
                CH_AMP:  entry_cls = CLS_AMP;
                CH_NL:   entry_cls = r_nl_break ? CLS_BR : CLS_PASS;
                default: begin
                    // printable ASCII passes, controls and DEL go decimal
                    if ({1'b0, cp_low} >= CH_SPACE && {1'b0, cp_low} != CH_DEL) begin
                        entry_cls = CLS_PASS;
                    end else begin
                        entry_cls = CLS_DEC;
                    end
                end
            endcase
        end
    end

    assign st_valid[0]     = i_item.valid;
    assign i_item.ready    = st_ready[0];
    assign st_work[0].cls  = entry_cls;
    assign st_work[0].ch   = {1'b0, cp_low};
    assign st_work[0].bin  = i_item.code_point;
    assign st_work[0].bcd  = '0;
    assign st_work[0].eot  = i_item.end_of_text;

    // binary to decimal, DD_STEPS bits per stage
    for (genvar g = 0; g < BCD_STAGES; g++) begin : g_bcd
        cphe_bcd_stage u_bcd (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (st_valid[g]),
            .o_ready (st_ready[g]),
            .i_work  (st_work[g]),
            .o_valid (st_valid[g+1]),
            .i_ready (st_ready[g+1]),
            .o_work  (st_work[g+1])
        );
    end

    // formatting and byte serialization
    cphe_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (st_valid[BCD_STAGES]),
        .o_ready (st_ready[BCD_STAGES]),
        .i_work  (st_work[BCD_STAGES]),
        .o_valid (o_result.valid),
        .i_ready (o_result.ready),
        .o_res   (res)
    );

    assign o_result.out_byte      = res.out_byte;
    assign o_result.last_of_item  = res.last_of_item;
    assign o_result.end_of_string = res.end_of_string;

endmodule

// File: tb/code_point_html_escape_unit_tb.sv
// Self-checking testbench for the code point HTML escaper.
`timescale 1ns / 1ps
module code_point_html_escape_unit_tb;
    import cphe_pkg::*;

    localparam int IDLE_PCT    = 35;    // chance in 100 that a side idles in a cycle
    localparam int CALM_LO     = 140;   // no idling while this many ..
    localparam int CALM_HI     = 230;   // .. to this many code points have been accepted
    localparam int HOLD_AT     = 160;   // long receiver stall starts here
    localparam int HOLD_CYCLES = 90;
    localparam int SETTLE      = 8;     // pipeline depth plus margin
    localparam int STALL_LIMIT = 1000;  // cycles without any transfer
    localparam int RAND_PHASE  = 72;
    localparam int MAX_REPORTS = 40;

    // corner code points: every named entity, newline, the printable range
    // bounds, control characters, DEL, and decimal lengths of 1 to 3 and 5 to 7
    // digits up to the 21-bit maximum (surrogate and beyond-Unicode values included)
    localparam int unsigned CORNER_CPS [20] = '{
        0, 9, int'(CH_NL), 'h1F, int'(CH_SPACE), int'(CH_QUOT), int'(CH_AMP),
        int'(CH_APOS), int'(CH_LT), int'(CH_GT), 'h41, 'h7E, int'(CH_DEL), 'h80,
        'hD800, 'hFFFF, 999999, 'h10FFFF, 'h110000, 'h1FFFFF
    };

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            eot;
    } t_char;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic i_cfg_wr_data;

    cphe_in_if  in_ch ();
    cphe_out_if out_ch ();

    code_point_html_escape_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_item        (in_ch),
        .o_result      (out_ch)
    );

    t_char  text_q[$];      // code points waiting to be offered
    t_res   escaped_q[$];   // escaped bytes still owed by the block
    t_res   want;
    t_char  nxt;
    logic   break_mode;     // our copy of newline_as_break
    int     n_cp_in;
    int     n_bytes_out;
    int     n_err;
    int     hold_left;
    bit     hold_done;
    int     idle_cycles;

    wire calm = (n_cp_in >= CALM_LO) && (n_cp_in < CALM_HI);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        if (n_err < MAX_REPORTS)
            $display("mismatch @%0t: %s", $time, msg);
        n_err++;
    endtask

    // expected byte stream for one code point under the current break mode
    function automatic void push_escaped(input logic [CP_W-1:0] cp, input logic eot);
        string txt;
        t_res  r;
        case (cp)
            CP_W'(CH_APOS): txt = "&apos;";
            CP_W'(CH_QUOT): txt = "&quot;";
            CP_W'(CH_LT):   txt = "&lt;";
            CP_W'(CH_GT):   txt = "&gt;";
            CP_W'(CH_AMP):  txt = "&amp;";
            CP_W'(CH_NL):   txt = break_mode ? "<br/>" : "\n";
            default: begin
                if (cp >= CH_SPACE && cp < CH_DEL) begin
                    txt = " ";
                    txt.putc(0, cp[7:0]);
                end else begin
                    txt = $sformatf("&#%0d;", cp);
                end
            end
        endcase
        for (int k = 0; k < txt.len(); k++) begin
            r.out_byte      = txt[k];
            r.last_of_item  = (k == txt.len() - 1);
            r.end_of_string = (k == txt.len() - 1) && eot;
            escaped_q.push_back(r);
        end
    endfunction

    function automatic logic [CP_W-1:0] rand_code_point();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 15) begin
            case ($urandom_range(5))
                0: return CP_W'(CH_APOS);
                1: return CP_W'(CH_QUOT);
                2: return CP_W'(CH_LT);
                3: return CP_W'(CH_GT);
                4: return CP_W'(CH_AMP);
                default: return CP_W'(CH_NL);
            endcase
        end
        if (sel < 55) return CP_W'($urandom_range('h20, 'h7E));
        if (sel < 63) return ($urandom_range(8) == 0) ? CP_W'(CH_DEL) : CP_W'($urandom_range(31));
        if (sel < 80) return CP_W'($urandom_range('h80, 'hFFFF));
        if (sel < 92) return CP_W'($urandom_range('h10000, 'h10FFFF));
        return CP_W'($urandom_range('h1FFFFF));
    endfunction

    // text of random strings, each closed by end_of_text; a few strings lose
    // their end marker and a few stray markers land mid-string
    task automatic queue_strings(input int n);
        int len;
        int cnt;
        t_char c;
        cnt = 0;
        while (cnt < n) begin
            len = $urandom_range(1, 12);
            for (int k = 0; k < len; k++) begin
                c.cp  = rand_code_point();
                c.eot = (k == len - 1) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0);
                text_q.push_back(c);
            end
            cnt += len;
        end
    endtask

    task automatic queue_char(input int unsigned cp, input logic eot);
        t_char c;
        c.cp  = CP_W'(cp);
        c.eot = eot;
        text_q.push_back(c);
    endtask

    // sender pause: everything offered, accepted and answered, then settle
    task automatic wait_idle();
        while (text_q.size() != 0 || in_ch.valid || escaped_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_break(input logic v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        break_mode = v;
        @(negedge i_clk);
    endtask

    // Sender: one code point per transfer, fed from text_q.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid       <= 1'b0;
            in_ch.code_point  <= '0;
            in_ch.end_of_text <= 1'b0;
            n_cp_in           <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                push_escaped(in_ch.code_point, in_ch.end_of_text);
                n_cp_in <= n_cp_in + 1;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (text_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    nxt = text_q.pop_front();
                    in_ch.valid       <= 1'b1;
                    in_ch.code_point  <= nxt.cp;
                    in_ch.end_of_text <= nxt.eot;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each byte transfer against the oldest expected byte.
    // One long hold-off lets the pipeline fill and back-pressure the sender.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
            n_bytes_out  <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                n_bytes_out <= n_bytes_out + 1;
                if (escaped_q.size() == 0) begin
                    report_mismatch($sformatf("byte %0d: unexpected %02h", n_bytes_out,
                                              out_ch.out_byte));
                end else begin
                    want = escaped_q.pop_front();
                    if (out_ch.out_byte !== want.out_byte)
                        report_mismatch($sformatf("byte %0d: out_byte %02h, want %02h",
                                                  n_bytes_out, out_ch.out_byte, want.out_byte));
                    if (out_ch.last_of_item !== want.last_of_item)
                        report_mismatch($sformatf("byte %0d: last_of_item %b, want %b",
                                                  n_bytes_out, out_ch.last_of_item,
                                                  want.last_of_item));
                    if (out_ch.end_of_string !== want.end_of_string)
                        report_mismatch($sformatf("byte %0d: end_of_string %b, want %b",
                                                  n_bytes_out, out_ch.end_of_string,
                                                  want.end_of_string));
                end
            end
            if (!hold_done && n_cp_in >= HOLD_AT) begin
                hold_done    <= 1'b1;
                hold_left    <= HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left    <= hold_left - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog: a run that stops moving is a failure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_wr_en       = 1'b0;
        i_cfg_wr_data     = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.code_point  = '0;
        in_ch.end_of_text = 1'b0;
        out_ch.ready      = 1'b0;
        break_mode        = 1'b0;
        n_err             = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed corners with the break mode at its reset value
        foreach (CORNER_CPS[k])
            queue_char(CORNER_CPS[k], (k % 5 == 4));
        wait_idle();

        // newline as <br/>, with and without end of text
        set_break(1'b1);
        queue_char(CH_NL, 1'b0);
        queue_char(CH_NL, 1'b1);
        queue_char(CH_LT, 1'b0);
        queue_char('h1FFFFF, 1'b1);
        wait_idle();

        // random strings, break mode toggled between phases
        for (int p = 0; p < 4; p++) begin
            set_break(p[0]);
            queue_strings(RAND_PHASE);
            wait_idle();
        end

        if (escaped_q.size() != 0)
            report_mismatch($sformatf("%0d expected bytes never arrived", escaped_q.size()));
        if (n_err == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
